// ===== sv/dmac_pkg.sv =====
// Shared types, codes and helper functions for the register-mapped DMA copier.
package dmac_pkg;

  localparam int BURST_BYTES = 32;
  localparam int NUM_REGS    = 8;
  localparam int DATA_W      = 32;
  localparam int MEM_LEN_W   = 6;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    RESP_OK    = 2'd0,
    RESP_BE    = 2'd1,
    RESP_BURST = 2'd2
  } bus_resp_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } mem_cmd_t;

  typedef enum logic [1:0] {
    MEM_OK       = 2'd0,
    MEM_ADDR_ERR = 2'd1
  } mem_status_t;

  localparam logic [2:0] REG_DST     = 3'd0;
  localparam logic [2:0] REG_SRC     = 3'd1;
  localparam logic [2:0] REG_LEN     = 3'd2;
  localparam logic [2:0] REG_CTRL    = 3'd3;
  localparam logic [2:0] REG_BYTE_EN = 3'd4;
  localparam logic [2:0] REG_ERR     = 3'd5;

  localparam int CTRL_RUN  = 0;
  localparam int CTRL_DONE = 1;

  localparam logic [DATA_W-1:0] ERR_NONE  = 32'd0;
  localparam logic [DATA_W-1:0] ERR_ADDR  = 32'd3;
  localparam logic [DATA_W-1:0] ERR_OTHER = 32'd2;

  localparam logic [3:0] MAX_ACCESS_BYTES = 4'd4;
  localparam logic [DATA_W-1:0] CTRL_READ_LEN = 32'd4;
  localparam logic [DATA_W-1:0] BURST_LEN = DATA_W'(BURST_BYTES);

  typedef struct packed {
    logic [1:0]           bus_resp;
    logic [DATA_W-1:0]    read_data;
    logic [1:0]           mem_cmd;
    logic [DATA_W-1:0]    mem_addr;
    logic [MEM_LEN_W-1:0] mem_len;
    logic [DATA_W-1:0]    mem_byte_enable;
    logic                 irq_level;
    logic                 last_result;
  } result_t;

  typedef struct packed {
    logic fire;
    logic two;
  } push_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] nbytes);
    logic [DATA_W-1:0] m;
    case (nbytes)
      4'd0:    m = 32'h0000_0000;
      4'd1:    m = 32'h0000_00FF;
      4'd2:    m = 32'h0000_FFFF;
      4'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] err_code(input logic [1:0] st);
    logic [DATA_W-1:0] e;
    case (st)
      MEM_OK:       e = ERR_NONE;
      MEM_ADDR_ERR: e = ERR_ADDR;
      default:      e = ERR_OTHER;
    endcase
    return e;
  endfunction

endpackage

// ===== sv/register_mapped_dma_copier.sv =====
// Top level of the register-mapped DMA copier.
// Each request (register read, register write or copy tick) is captured in an input
// register, decoded against the eight-entry register file in one pass and its results
// go to a two-slot output register. Register accesses and idle ticks give one result
// and sustain one request per cycle while the output is ready; a copy tick that moves
// data gives a read and a write result, which leave in turn through the single result
// port. A held request moves on once the output is empty or its only result is taken.
module register_mapped_dma_copier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [3:0]  access_bytes,
  input  logic [3:0]  stream_width,
  input  logic        byte_enable_given,
  input  logic [1:0]  read_status,
  input  logic [1:0]  write_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  bus_resp,
  output logic [31:0] read_data,
  output logic [1:0]  mem_cmd,
  output logic [31:0] mem_addr,
  output logic [5:0]  mem_len,
  output logic [31:0] mem_byte_enable,
  output logic        irq_level,
  output logic        last_result
);

  dmac_pkg::push_t   push;
  dmac_pkg::result_t res0;
  dmac_pkg::result_t res1;
  dmac_pkg::result_t out_res;
  logic              can_take;

  dmac_core u_core (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .req_type          (req_type),
    .reg_index         (reg_index),
    .write_data        (write_data),
    .access_bytes      (access_bytes),
    .stream_width      (stream_width),
    .byte_enable_given (byte_enable_given),
    .read_status       (read_status),
    .write_status      (write_status),
    .can_take          (can_take),
    .push              (push),
    .res0              (res0),
    .res1              (res1)
  );

  dmac_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign bus_resp        = out_res.bus_resp;
  assign read_data       = out_res.read_data;
  assign mem_cmd         = out_res.mem_cmd;
  assign mem_addr        = out_res.mem_addr;
  assign mem_len         = out_res.mem_len;
  assign mem_byte_enable = out_res.mem_byte_enable;
  assign irq_level       = out_res.irq_level;
  assign last_result     = out_res.last_result;

endmodule

// ===== sv/dmac_core.sv =====
// Request register, register file and single-pass request decode for the DMA copier.
module dmac_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [2:0]        reg_index,
  input  logic [31:0]       write_data,
  input  logic [3:0]        access_bytes,
  input  logic [3:0]        stream_width,
  input  logic              byte_enable_given,
  input  logic [1:0]        read_status,
  input  logic [1:0]        write_status,
  input  logic              can_take,
  output dmac_pkg::push_t   push,
  output dmac_pkg::result_t res0,
  output dmac_pkg::result_t res1
);

  logic        hold_valid;
  logic [1:0]  h_req_type;
  logic [2:0]  h_reg_index;
  logic [31:0] h_write_data;
  logic [3:0]  h_access_bytes;
  logic [3:0]  h_stream_width;
  logic        h_byte_enable_given;
  logic [1:0]  h_read_status;
  logic [1:0]  h_write_status;

  logic [dmac_pkg::DATA_W-1:0] regs [dmac_pkg::NUM_REGS];
  logic [dmac_pkg::DATA_W-1:0] regs_next [dmac_pkg::NUM_REGS];
  logic                        irq;
  logic                        irq_next;

  logic                        fire;
  logic                        two;
  logic                        burst;
  logic [dmac_pkg::DATA_W-1:0] mask;
  logic [dmac_pkg::DATA_W-1:0] tlen;
  logic [dmac_pkg::DATA_W-1:0] len_after;

  assign fire     = hold_valid && can_take;
  assign in_ready = !hold_valid || fire;
  assign push     = '{fire: fire, two: two};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      h_req_type          <= req_type;
      h_reg_index         <= reg_index;
      h_write_data        <= write_data;
      h_access_bytes      <= access_bytes;
      h_stream_width      <= stream_width;
      h_byte_enable_given <= byte_enable_given;
      h_read_status       <= read_status;
      h_write_status      <= write_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dmac_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      irq <= 1'b0;
    end else if (fire) begin
      regs <= regs_next;
      irq  <= irq_next;
    end
  end

  always_comb begin
    regs_next = regs;
    irq_next  = irq;
    res0      = '0;
    res1      = '0;
    two       = 1'b0;
    burst     = 1'b0;
    mask      = dmac_pkg::byte_mask(h_access_bytes);
    tlen      = (regs[dmac_pkg::REG_LEN] > dmac_pkg::BURST_LEN) ?
                dmac_pkg::BURST_LEN : regs[dmac_pkg::REG_LEN];
    len_after = regs[dmac_pkg::REG_LEN];
    case (h_req_type)
      dmac_pkg::REQ_READ, dmac_pkg::REQ_WRITE: begin
        if (h_byte_enable_given) begin
          res0.bus_resp = dmac_pkg::RESP_BE;
        end else if (h_access_bytes > dmac_pkg::MAX_ACCESS_BYTES ||
                     h_stream_width < h_access_bytes) begin
          res0.bus_resp = dmac_pkg::RESP_BURST;
        end else if (h_req_type == dmac_pkg::REQ_READ) begin
          res0.read_data = regs[h_reg_index] & mask;
        end else begin
          regs_next[h_reg_index] = (regs[h_reg_index] & ~mask) | (h_write_data & mask);
          if (h_reg_index == dmac_pkg::REG_CTRL) begin
            regs_next[dmac_pkg::REG_ERR] = dmac_pkg::err_code(h_read_status);
            res0.mem_cmd         = dmac_pkg::CMD_READ;
            res0.mem_addr        = regs[dmac_pkg::REG_SRC];
            res0.mem_len         = dmac_pkg::CTRL_READ_LEN[dmac_pkg::MEM_LEN_W-1:0];
            res0.mem_byte_enable = regs[dmac_pkg::REG_BYTE_EN];
          end
        end
      end
      dmac_pkg::REQ_TICK: begin
        burst = regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_RUN] &&
                (regs[dmac_pkg::REG_LEN] != '0);
        if (burst) begin
          len_after = regs[dmac_pkg::REG_LEN] - tlen;
          regs_next[dmac_pkg::REG_DST] = regs[dmac_pkg::REG_DST] + tlen;
          regs_next[dmac_pkg::REG_SRC] = regs[dmac_pkg::REG_SRC] + tlen;
          regs_next[dmac_pkg::REG_LEN] = len_after;
          regs_next[dmac_pkg::REG_ERR] = dmac_pkg::err_code(h_write_status);
          two                  = 1'b1;
          res0.mem_cmd         = dmac_pkg::CMD_READ;
          res0.mem_addr        = regs[dmac_pkg::REG_SRC];
          res0.mem_len         = tlen[dmac_pkg::MEM_LEN_W-1:0];
          res0.mem_byte_enable = regs[dmac_pkg::REG_BYTE_EN];
          res1.mem_cmd         = dmac_pkg::CMD_WRITE;
          res1.mem_addr        = regs[dmac_pkg::REG_DST];
          res1.mem_len         = tlen[dmac_pkg::MEM_LEN_W-1:0];
          res1.mem_byte_enable = regs[dmac_pkg::REG_BYTE_EN];
        end
        if (len_after == '0 && regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_RUN]) begin
          regs_next[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_RUN]  = 1'b0;
          regs_next[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_DONE] = 1'b1;
        end
        irq_next = regs_next[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_DONE];
      end
      default: begin
      end
    endcase
    res0.irq_level   = irq_next;
    res1.irq_level   = irq_next;
    res0.last_result = !two;
    res1.last_result = 1'b1;
  end

endmodule

// ===== sv/dmac_outbuf.sv =====
// Two-slot result register; presents one result per cycle while the output is ready.
module dmac_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  dmac_pkg::push_t   push,
  input  dmac_pkg::result_t res0,
  input  dmac_pkg::result_t res1,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output dmac_pkg::result_t out_res
);

  logic              pend_valid;
  dmac_pkg::result_t pend_res;
  logic              pop;

  assign pop      = out_valid && out_ready;
  assign can_take = !out_valid || (out_ready && !pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (push.fire) begin
      out_valid  <= 1'b1;
      pend_valid <= push.two;
    end else if (pop) begin
      out_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
    if (push.fire) begin
      out_res  <= res0;
      pend_res <= res1;
    end else if (pop && pend_valid) begin
      out_res <= pend_res;
    end
  end

`ifndef SYNTH
  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid) else $error("pending result without a current one");
  a_pend_not_last: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !out_res.last_result) else $error("last result shown before pending one");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.fire |-> can_take) else $error("push into a full result buffer");
  a_two_fill: assert property (@(posedge clk) disable iff (rst)
    push.fire && push.two |=> pend_valid && out_valid) else $error("second result lost");
`endif

endmodule

// ===== bench/register_mapped_dma_copier_tb.sv =====
// Self-checking testbench for the register-mapped DMA copier: random and directed requests.
module register_mapped_dma_copier_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int LIMIT_CYCLES = 250000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  idx;
    logic [31:0] wdata;
    logic [3:0]  nbytes;
    logic [3:0]  swidth;
    logic        be_given;
    logic [1:0]  rd_st;
    logic [1:0]  wr_st;
  } dma_request_t;

  class dma_copy_scoreboard;
    logic [31:0]         regs [dmac_pkg::NUM_REGS];
    logic                irq;
    dmac_pkg::result_t   awaited_results[$];
    int                  errors;
    int                  requests;
    int                  results;
    int                  bursts;
    int                  rejects;

    function new();
      foreach (regs[i]) regs[i] = '0;
      irq = 1'b0;
      errors = 0;
      requests = 0;
      results = 0;
      bursts = 0;
      rejects = 0;
    endfunction

    function logic [31:0] keep_mask(logic [3:0] n);
      if (n >= dmac_pkg::MAX_ACCESS_BYTES) return '1;
      return (32'd1 << (n * 8)) - 32'd1;
    endfunction

    function logic [31:0] status_word(logic [1:0] st);
      if (st == dmac_pkg::MEM_OK) return dmac_pkg::ERR_NONE;
      return (st == dmac_pkg::MEM_ADDR_ERR) ? dmac_pkg::ERR_ADDR : dmac_pkg::ERR_OTHER;
    endfunction

    function void note_request(dma_request_t r);
      dmac_pkg::result_t e;
      logic [31:0]       m;
      logic [31:0]       tlen;
      logic [31:0]       src;
      logic [31:0]       dst;
      logic [31:0]       be;
      bit                burst;
      requests++;
      e = '0;
      e.last_result = 1'b1;
      burst = 0;
      case (r.kind)
        dmac_pkg::REQ_READ, dmac_pkg::REQ_WRITE: begin
          if (r.be_given) begin
            e.bus_resp = dmac_pkg::RESP_BE;
            rejects++;
          end else if (r.nbytes > dmac_pkg::MAX_ACCESS_BYTES || r.swidth < r.nbytes) begin
            e.bus_resp = dmac_pkg::RESP_BURST;
            rejects++;
          end else begin
            m = keep_mask(r.nbytes);
            if (r.kind == dmac_pkg::REQ_READ) begin
              e.read_data = regs[r.idx] & m;
            end else begin
              regs[r.idx] = (regs[r.idx] & ~m) | (r.wdata & m);
              if (r.idx == dmac_pkg::REG_CTRL) begin
                regs[dmac_pkg::REG_ERR] = status_word(r.rd_st);
                e.mem_cmd = dmac_pkg::CMD_READ;
                e.mem_addr = regs[dmac_pkg::REG_SRC];
                e.mem_len = dmac_pkg::MEM_LEN_W'(dmac_pkg::CTRL_READ_LEN);
                e.mem_byte_enable = regs[dmac_pkg::REG_BYTE_EN];
              end
            end
          end
        end
        dmac_pkg::REQ_TICK: begin
          if (regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_RUN] && regs[dmac_pkg::REG_LEN] != 0) begin
            tlen = (regs[dmac_pkg::REG_LEN] > dmac_pkg::BURST_LEN) ?
                   dmac_pkg::BURST_LEN : regs[dmac_pkg::REG_LEN];
            src = regs[dmac_pkg::REG_SRC];
            dst = regs[dmac_pkg::REG_DST];
            be = regs[dmac_pkg::REG_BYTE_EN];
            regs[dmac_pkg::REG_ERR] = status_word(r.rd_st);
            regs[dmac_pkg::REG_ERR] = status_word(r.wr_st);
            regs[dmac_pkg::REG_DST] = dst + tlen;
            regs[dmac_pkg::REG_SRC] = src + tlen;
            regs[dmac_pkg::REG_LEN] = regs[dmac_pkg::REG_LEN] - tlen;
            burst = 1;
            bursts++;
          end
          if (regs[dmac_pkg::REG_LEN] == 0 && regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_RUN]) begin
            regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_RUN] = 1'b0;
            regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_DONE] = 1'b1;
          end
          irq = regs[dmac_pkg::REG_CTRL][dmac_pkg::CTRL_DONE];
          if (burst) begin
            e.mem_cmd = dmac_pkg::CMD_READ;
            e.mem_addr = src;
            e.mem_len = tlen[dmac_pkg::MEM_LEN_W-1:0];
            e.mem_byte_enable = be;
            e.irq_level = irq;
            e.last_result = 1'b0;
            awaited_results.push_back(e);
            e.mem_cmd = dmac_pkg::CMD_WRITE;
            e.mem_addr = dst;
            e.last_result = 1'b1;
          end
        end
        default: ;
      endcase
      e.irq_level = irq;
      awaited_results.push_back(e);
    endfunction

    function void compare(string field, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp, got);
      end
    endfunction

    function void check_result(dmac_pkg::result_t got);
      dmac_pkg::result_t exp;
      results++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0h", $time, got);
        return;
      end
      exp = awaited_results.pop_front();
      compare("bus_resp", 32'(exp.bus_resp), 32'(got.bus_resp));
      compare("read_data", exp.read_data, got.read_data);
      compare("mem_cmd", 32'(exp.mem_cmd), 32'(got.mem_cmd));
      compare("mem_addr", exp.mem_addr, got.mem_addr);
      compare("mem_len", 32'(exp.mem_len), 32'(got.mem_len));
      compare("mem_byte_enable", exp.mem_byte_enable, got.mem_byte_enable);
      compare("irq_level", 32'(exp.irq_level), 32'(got.irq_level));
      compare("last_result", 32'(exp.last_result), 32'(got.last_result));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [2:0]  reg_index = '0;
  logic [31:0] write_data = '0;
  logic [3:0]  access_bytes = '0;
  logic [3:0]  stream_width = '0;
  logic        byte_enable_given = 1'b0;
  logic [1:0]  read_status = '0;
  logic [1:0]  write_status = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  bus_resp;
  logic [31:0] read_data;
  logic [1:0]  mem_cmd;
  logic [31:0] mem_addr;
  logic [5:0]  mem_len;
  logic [31:0] mem_byte_enable;
  logic        irq_level;
  logic        last_result;

  dma_copy_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;
  int cycles = 0;

  register_mapped_dma_copier u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .reg_index(reg_index),
    .write_data(write_data),
    .access_bytes(access_bytes),
    .stream_width(stream_width),
    .byte_enable_given(byte_enable_given),
    .read_status(read_status),
    .write_status(write_status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bus_resp(bus_resp),
    .read_data(read_data),
    .mem_cmd(mem_cmd),
    .mem_addr(mem_addr),
    .mem_len(mem_len),
    .mem_byte_enable(mem_byte_enable),
    .irq_level(irq_level),
    .last_result(last_result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({bus_resp, read_data, mem_cmd, mem_addr, mem_len, mem_byte_enable,
                       irq_level, last_result});
    end
  end

  function automatic dma_request_t build(logic [1:0] kind, logic [2:0] idx, logic [31:0] data,
                                         logic [3:0] nbytes, logic [3:0] swidth, logic be);
    dma_request_t r;
    r.kind = kind;
    r.idx = idx;
    r.wdata = data;
    r.nbytes = nbytes;
    r.swidth = swidth;
    r.be_given = be;
    r.rd_st = 2'($urandom_range(2));
    r.wr_st = 2'($urandom_range(2));
    return r;
  endfunction

  function automatic logic [31:0] rand_addr();
    return ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(64) : $urandom;
  endfunction

  task automatic send_request(input dma_request_t r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    reg_index <= r.idx;
    write_data <= r.wdata;
    access_bytes <= r.nbytes;
    stream_width <= r.swidth;
    byte_enable_given <= r.be_given;
    read_status <= r.rd_st;
    write_status <= r.wr_st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    send_request(build(dmac_pkg::REQ_WRITE, idx, data, 4'd4, 4'($urandom_range(4, 8)), 1'b0));
  endtask

  task automatic read_reg(input logic [2:0] idx);
    send_request(build(dmac_pkg::REQ_READ, idx, $urandom, 4'd4, 4'($urandom_range(4, 8)),
                       1'b0));
  endtask

  task automatic copy_tick();
    send_request(build(dmac_pkg::REQ_TICK, 3'($urandom_range(7)), $urandom,
                       4'($urandom_range(8)), 4'($urandom_range(8)), 1'($urandom_range(1))));
  endtask

  task automatic random_copy_run();
    logic [31:0] total;
    logic [31:0] ctrl_word;
    int          ticks;
    write_reg(dmac_pkg::REG_SRC, rand_addr());
    write_reg(dmac_pkg::REG_DST, rand_addr());
    total = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(96);
    write_reg(dmac_pkg::REG_LEN, total);
    if ($urandom_range(5) != 0) write_reg(dmac_pkg::REG_BYTE_EN, $urandom);
    ctrl_word = $urandom;
    ctrl_word[dmac_pkg::CTRL_RUN] = 1'b1;
    write_reg(dmac_pkg::REG_CTRL, ctrl_word);
    ticks = total / dmac_pkg::BURST_BYTES + 2;
    repeat (ticks) begin
      if ($urandom_range(3) == 0) read_reg(3'($urandom_range(7)));
      copy_tick();
    end
  endtask

  task automatic run_phase(input int sidle, input int ridle, input int count);
    int target;
    target = sent + count;
    send_idle = sidle;
    recv_idle = ridle;
    while (sent < target) begin
      if ($urandom_range(99) < 70) begin
        random_copy_run();
      end else begin
        send_request(build(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom,
                           4'($urandom_range(8)), 4'($urandom_range(8)),
                           $urandom_range(4) == 0));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle = 20;
    recv_idle = 30;
    read_reg(dmac_pkg::REG_DST);
    send_request(build(dmac_pkg::REQ_WRITE, dmac_pkg::REG_SRC, 32'hFFFF_FFF0, 4'd4, 4'd8, 1'b0));
    send_request(build(dmac_pkg::REQ_WRITE, dmac_pkg::REG_DST, 32'h1000_0000, 4'd4, 4'd4, 1'b0));
    write_reg(dmac_pkg::REG_LEN, 32'd40);
    write_reg(dmac_pkg::REG_BYTE_EN, 32'hA5A5_5A5A);
    write_reg(dmac_pkg::REG_CTRL, 32'h0000_0001);
    copy_tick();
    copy_tick();
    copy_tick();
    read_reg(dmac_pkg::REG_CTRL);
    send_request(build(dmac_pkg::REQ_WRITE, dmac_pkg::REG_CTRL, 32'h0, 4'd0, 4'd0, 1'b0));
    send_request(build(dmac_pkg::REQ_WRITE, dmac_pkg::REG_CTRL, 32'hFFFF_FF00, 4'd1, 4'd1,
                       1'b0));
    send_request(build(dmac_pkg::REQ_READ, dmac_pkg::REG_SRC, 32'h0, 4'd4, 4'd4, 1'b1));
    send_request(build(dmac_pkg::REQ_WRITE, dmac_pkg::REG_LEN, 32'hFFFF_FFFF, 4'd5, 4'd8, 1'b0));
    send_request(build(dmac_pkg::REQ_READ, dmac_pkg::REG_DST, 32'h0, 4'd4, 4'd3, 1'b0));
    send_request(build(dmac_pkg::REQ_READ, dmac_pkg::REG_DST, 32'h0, 4'd8, 4'd8, 1'b0));
    send_request(build(dmac_pkg::REQ_WRITE, REG_SPARE_B, 32'hFFFF_FFFF, 4'd2, 4'd2, 1'b0));
    send_request(build(dmac_pkg::REQ_READ, REG_SPARE_B, 32'h0, 4'd3, 4'd8, 1'b0));
    send_request(build(REQ_UNUSED, REG_SPARE_B, 32'hFFFF_FFFF, 4'd8, 4'd8, 1'b1));
    copy_tick();
    send_request(build(dmac_pkg::REQ_WRITE, REG_SPARE_A, 32'hFFFF_FFFF, 4'd0, 4'd0, 1'b0));
    write_reg(dmac_pkg::REG_LEN, 32'd0);
    write_reg(dmac_pkg::REG_CTRL, 32'h0000_0001);
    copy_tick();
    read_reg(dmac_pkg::REG_ERR);

    run_phase(37, 54, 400);
    run_phase(54, 37, 400);
    run_phase(0, 0, 400);
    in_valid <= 1'b0;

    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.awaited_results.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.awaited_results.size());
    end
    $display("Covered %0d requests and %0d results: %0d copy bursts, %0d rejected accesses",
             sb.requests, sb.results, sb.bursts, sb.rejects);
    $display("Mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== register_mapped_dma_copier.f =====
sv/dmac_pkg.sv
sv/dmac_core.sv
sv/dmac_outbuf.sv
sv/register_mapped_dma_copier.sv
bench/register_mapped_dma_copier_tb.sv
